[hdl/nwdp_pkg.sv]
// Package for the noisy-weight dot product: constants, register indexes,
// controller state type and the command/status words between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package nwdp_pkg;

  localparam int VALUE_BITS_DEF = 16;
  localparam int ACC_BITS_DEF   = 48;

  localparam int FRAC_BITS  = 12;
  localparam int NOISE_FRAC = 23;
  localparam int DRIFT_FRAC = 15;
  localparam int NOISE_BITS = 24;
  localparam int MANT_BITS  = 23;
  localparam int DRIFT_BITS = 16;
  localparam int SEED_BITS  = 64;
  localparam int SUM_BITS   = 32;

  localparam int XS_SHIFT_A = 13;
  localparam int XS_SHIFT_B = 7;
  localparam int XS_SHIFT_C = 17;

  localparam logic [DRIFT_BITS-1:0] DRIFT_RESET = 16'd14746;
  localparam logic [SEED_BITS-1:0]  SEED_RESET  = 64'd1;

  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS  = SEED_BITS;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_DRIFT_GAIN = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SEED_VALUE = 1'd1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RNG,
    S_NOISE,
    S_RNDN,
    S_SPREAD,
    S_WEIGHT,
    S_PROD,
    S_ACC,
    S_EMIT
  } nwdp_state_t;

  typedef struct packed {
    logic load_item;
    logic adv_rng;
    logic calc_noise;
    logic round_noise;
    logic calc_spread;
    logic calc_weight;
    logic calc_prod;
    logic accumulate;
    logic emit;
  } nwdp_cmd_t;

  typedef struct packed {
    logic row_start;
    logic item_last;
    logic out_busy;
  } nwdp_status_t;

endpackage

`default_nettype wire

[hdl/nwdp_if.sv]
// Stream interfaces of the noisy-weight dot product: input element word and row-sum word.
// Depends on nwdp_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface nwdp_in_if #(
  parameter int VALUE_BITS = nwdp_pkg::VALUE_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] x_value;
  logic signed [VALUE_BITS-1:0] weight_mean;
  logic signed [VALUE_BITS-1:0] weight_spread;
  logic                         last_of_row;

  modport source (output valid, x_value, weight_mean, weight_spread, last_of_row,
                  input ready);
  modport sink   (input valid, x_value, weight_mean, weight_spread, last_of_row,
                  output ready);
endinterface

interface nwdp_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [nwdp_pkg::SUM_BITS-1:0] row_sum;

  modport source (output valid, row_sum, input ready);
  modport sink   (input valid, row_sum, output ready);
endinterface

`default_nettype wire

[hdl/nwdp_ctrl.sv]
// Controller of the noisy-weight dot product: sequences one element word through
// the datapath steps. Depends on nwdp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nwdp_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire nwdp_pkg::nwdp_status_t status,
  output nwdp_pkg::nwdp_cmd_t         cmd
);
  import nwdp_pkg::*;

  nwdp_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = status.row_start ? S_RNG : S_SPREAD;
        end
      end
      S_RNG: begin
        cmd.adv_rng = 1'b1;
        state_nxt   = S_NOISE;
      end
      S_NOISE: begin
        cmd.calc_noise = 1'b1;
        state_nxt      = S_RNDN;
      end
      S_RNDN: begin
        cmd.round_noise = 1'b1;
        state_nxt       = S_SPREAD;
      end
      S_SPREAD: begin
        cmd.calc_spread = 1'b1;
        state_nxt       = S_WEIGHT;
      end
      S_WEIGHT: begin
        cmd.calc_weight = 1'b1;
        state_nxt       = S_PROD;
      end
      S_PROD: begin
        cmd.calc_prod = 1'b1;
        state_nxt     = S_ACC;
      end
      S_ACC: begin
        cmd.accumulate = 1'b1;
        state_nxt      = status.item_last ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        // hold until the output register is free
        if (!status.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[hdl/nwdp_datapath.sv]
// Datapath of the noisy-weight dot product: generator, noise scaling, weight,
// product, accumulator and output register. Depends on nwdp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nwdp_datapath #(
  parameter int VALUE_BITS = nwdp_pkg::VALUE_BITS_DEF,
  parameter int ACC_BITS   = nwdp_pkg::ACC_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire nwdp_pkg::nwdp_cmd_t                  cmd,
  output nwdp_pkg::nwdp_status_t                    status,
  input  wire logic signed [VALUE_BITS-1:0]         in_x_value,
  input  wire logic signed [VALUE_BITS-1:0]         in_weight_mean,
  input  wire logic signed [VALUE_BITS-1:0]         in_weight_spread,
  input  wire logic                                 in_last_of_row,
  input  wire logic                                 cfg_we,
  input  wire logic [nwdp_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  wire logic [nwdp_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic signed [nwdp_pkg::SUM_BITS-1:0]      out_row_sum
);
  import nwdp_pkg::*;

  localparam int NMUL_W = MANT_BITS + DRIFT_BITS + 1;
  localparam int SMUL_W = VALUE_BITS + NOISE_BITS;
  localparam int WSUM_W = VALUE_BITS + 2;
  localparam int PROD_W = 2 * VALUE_BITS;
  localparam int ASUM_W = ((ACC_BITS > PROD_W) ? ACC_BITS : PROD_W) + 1;
  localparam int RSUM_W = ACC_BITS + 1;

  function automatic logic [SEED_BITS-1:0] xorshift64(input logic [SEED_BITS-1:0] s);
    logic [SEED_BITS-1:0] t;
    t = s ^ (s << XS_SHIFT_A);
    t = t ^ (t >> XS_SHIFT_B);
    t = t ^ (t << XS_SHIFT_C);
    return t;
  endfunction

  logic [DRIFT_BITS-1:0]        drift_r;
  logic [SEED_BITS-1:0]         rng_r;
  logic                         row_start_r;
  logic signed [NOISE_BITS-1:0] row_noise_r, row_noise_nxt;
  logic signed [NMUL_W-1:0]     noise_mul_r, noise_mul_nxt;
  logic signed [SMUL_W-1:0]     spread_mul_r, spread_mul_nxt;
  logic signed [VALUE_BITS-1:0] weight_r, weight_nxt;
  logic signed [PROD_W-1:0]     prod_r, prod_nxt;
  logic signed [ACC_BITS-1:0]   acc_r, acc_nxt;
  logic signed [VALUE_BITS-1:0] x_r, mean_r, spread_r;
  logic                         last_r;
  logic                         out_valid_r;
  logic signed [SUM_BITS-1:0]   out_sum_r, out_sum_nxt;

  logic signed [MANT_BITS-1:0]  noise_raw;
  logic signed [DRIFT_BITS:0]   drift_s;
  logic signed [NMUL_W-1:0]     noise_sh;
  logic [NMUL_W-1:0]            noise_rnd;
  logic signed [SMUL_W-1:0]     spread_sh;
  logic [SMUL_W-1:0]            spread_rnd;
  logic [WSUM_W-1:0]            weight_sum;
  logic signed [ASUM_W-1:0]     acc_sum;
  logic signed [ACC_BITS-1:0]   acc_sh;
  logic [RSUM_W-1:0]            row_rnd;

  // mantissa minus one half: flip the top bit to get signed Q0.23
  assign noise_raw     = {~rng_r[MANT_BITS-1], rng_r[MANT_BITS-2:0]};
  assign drift_s       = {1'b0, drift_r};
  assign noise_mul_nxt = noise_raw * drift_s;

  assign noise_sh      = noise_mul_r >>> DRIFT_FRAC;
  assign noise_rnd     = noise_sh + NMUL_W'(noise_mul_r[DRIFT_FRAC-1]);
  assign row_noise_nxt = noise_rnd[NOISE_BITS-1:0];

  assign spread_mul_nxt = spread_r * row_noise_r;

  assign spread_sh  = spread_mul_r >>> NOISE_FRAC;
  assign spread_rnd = spread_sh + SMUL_W'(spread_mul_r[NOISE_FRAC-1]);
  assign weight_sum = WSUM_W'(mean_r) + spread_rnd[WSUM_W-1:0];

  always_comb begin
    if (weight_sum[WSUM_W-1:VALUE_BITS-1] == {(WSUM_W-VALUE_BITS+1){weight_sum[WSUM_W-1]}}) begin
      weight_nxt = weight_sum[VALUE_BITS-1:0];
    end else if (weight_sum[WSUM_W-1]) begin
      weight_nxt = {1'b1, {(VALUE_BITS-1){1'b0}}};
    end else begin
      weight_nxt = {1'b0, {(VALUE_BITS-1){1'b1}}};
    end
  end

  assign prod_nxt = x_r * weight_r;

  assign acc_sum = ASUM_W'(acc_r) + ASUM_W'(prod_r);

  always_comb begin
    if (acc_sum[ASUM_W-1:ACC_BITS-1] == {(ASUM_W-ACC_BITS+1){acc_sum[ASUM_W-1]}}) begin
      acc_nxt = acc_sum[ACC_BITS-1:0];
    end else if (acc_sum[ASUM_W-1]) begin
      acc_nxt = {1'b1, {(ACC_BITS-1){1'b0}}};
    end else begin
      acc_nxt = {1'b0, {(ACC_BITS-1){1'b1}}};
    end
  end

  assign acc_sh  = acc_r >>> FRAC_BITS;
  assign row_rnd = RSUM_W'(acc_sh) + RSUM_W'(acc_r[FRAC_BITS-1]);

  always_comb begin
    if (row_rnd[RSUM_W-1:SUM_BITS-1] == {(RSUM_W-SUM_BITS+1){row_rnd[RSUM_W-1]}}) begin
      out_sum_nxt = row_rnd[SUM_BITS-1:0];
    end else if (row_rnd[RSUM_W-1]) begin
      out_sum_nxt = {1'b1, {(SUM_BITS-1){1'b0}}};
    end else begin
      out_sum_nxt = {1'b0, {(SUM_BITS-1){1'b1}}};
    end
  end

  // control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drift_r     <= DRIFT_RESET;
      rng_r       <= SEED_RESET;
      row_start_r <= 1'b1;
      row_noise_r <= '0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == CFG_DRIFT_GAIN) begin
        drift_r <= cfg_wdata[DRIFT_BITS-1:0];
      end
      if (cfg_we && cfg_index == CFG_SEED_VALUE) begin
        rng_r <= cfg_wdata[SEED_BITS-1:0];
      end else if (cmd.adv_rng) begin
        rng_r <= xorshift64(rng_r);
      end
      if (cmd.adv_rng) begin
        row_start_r <= 1'b0;
      end else if (cmd.emit) begin
        row_start_r <= 1'b1;
      end
      if (cmd.round_noise) begin
        row_noise_r <= row_noise_nxt;
      end
      if (cmd.emit) begin
        acc_r <= '0;
      end else if (cmd.accumulate) begin
        acc_r <= acc_nxt;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      x_r      <= in_x_value;
      mean_r   <= in_weight_mean;
      spread_r <= in_weight_spread;
      last_r   <= in_last_of_row;
    end
    if (cmd.calc_noise) begin
      noise_mul_r <= noise_mul_nxt;
    end
    if (cmd.calc_spread) begin
      spread_mul_r <= spread_mul_nxt;
    end
    if (cmd.calc_weight) begin
      weight_r <= weight_nxt;
    end
    if (cmd.calc_prod) begin
      prod_r <= prod_nxt;
    end
    if (cmd.emit) begin
      out_sum_r <= out_sum_nxt;
    end
  end

  assign status.row_start = row_start_r;
  assign status.item_last = last_r;
  assign status.out_busy  = out_valid_r && !out_ready;

  assign out_valid   = out_valid_r;
  assign out_row_sum = out_sum_r;

endmodule

`default_nettype wire

[hdl/noisy_weight_dot_product.sv]
// Top level of the noisy-weight dot product: controller plus datapath.
// Depends on nwdp_pkg, nwdp_if, nwdp_ctrl and nwdp_datapath.
//
//   channel  | direction | word                                              | handshake
//   ---------+-----------+---------------------------------------------------+------------
//   in_ch    | in        | x_value, weight_mean, weight_spread, last_of_row  | valid/ready
//   out_ch   | out       | row_sum (signed Q19.12, saturated)                | valid/ready
//   cfg_*    | in        | cfg_index, cfg_wdata                              | cfg_we only
//
// One element word is taken at a time. An ordinary element passes through the spread
// multiply, weight, product and accumulate steps before the next acceptance; the first
// element of a row also takes the generator step and the noise multiply and rounding,
// and the last element adds the emit step that loads the output register.
// Reset is synchronous, active low: generator state takes the reset seed, drift gain
// its default, accumulator clears and the next element starts a row.
// A stalled output holds the controller at the emit step only; the next word is still
// accepted while an earlier row sum waits to be taken.
`timescale 1ns / 1ps
`default_nettype none

module noisy_weight_dot_product #(
  parameter int VALUE_BITS = nwdp_pkg::VALUE_BITS_DEF,
  parameter int ACC_BITS   = nwdp_pkg::ACC_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  nwdp_in_if.sink                                  in_ch,
  nwdp_out_if.source                               out_ch,
  input  wire logic                                cfg_we,
  input  wire logic [nwdp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [nwdp_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);
  import nwdp_pkg::*;

  nwdp_cmd_t    cmd;
  nwdp_status_t status;
  logic         in_ready;
  logic         out_valid;
  logic signed [SUM_BITS-1:0] out_row_sum;

  // sequence each word through the datapath
  nwdp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // generator, weight arithmetic, accumulator and output register
  nwdp_datapath #(
    .VALUE_BITS (VALUE_BITS),
    .ACC_BITS   (ACC_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .in_x_value       (in_ch.x_value),
    .in_weight_mean   (in_ch.weight_mean),
    .in_weight_spread (in_ch.weight_spread),
    .in_last_of_row   (in_ch.last_of_row),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .out_valid        (out_valid),
    .out_ready        (out_ch.ready),
    .out_row_sum      (out_row_sum)
  );

  assign in_ch.ready    = in_ready;
  assign out_ch.valid   = out_valid;
  assign out_ch.row_sum = out_row_sum;

endmodule

`default_nettype wire

[sim/noisy_weight_dot_product_tb.sv]
// Self-checking testbench for the noisy-weight dot product: element words in, row sums out.
// Depends on nwdp_pkg, the stream interfaces in nwdp_if and the noisy_weight_dot_product top.
// Test tasks run in turn; a behavioural predictor queues the expected row sums.
`timescale 1ns / 1ps

module noisy_weight_dot_product_tb;
  import nwdp_pkg::*;

  localparam int VB = VALUE_BITS_DEF;
  localparam int AB = ACC_BITS_DEF;
  // Allow generously for the slowest element and the block to settle.
  localparam int SETTLE_CYCLES = 20;
  // Elements in each long row and random elements in total.
  localparam int LONG_ROW     = 150;
  localparam int RANDOM_ITEMS = 700;

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_wdata;

  nwdp_in_if #(.VALUE_BITS(VB)) in_bus ();
  nwdp_out_if                   out_bus ();

  noisy_weight_dot_product #(
    .VALUE_BITS(VB),
    .ACC_BITS  (AB)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_bus),
    .out_ch   (out_bus),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Shadow of the block: configuration, generator, held noise and accumulator.
  logic [DRIFT_BITS-1:0] shadow_drift;
  logic [SEED_BITS-1:0]  shadow_rng;
  longint                shadow_noise;
  longint                shadow_acc;
  logic                  shadow_row_start;

  logic signed [SUM_BITS-1:0] pending_sums[$];
  int                         error_count;
  // When set, neither side idles: a stretch at full rate.
  bit                         full_rate;

  function automatic longint round_shr(longint v, int k);
    return (v >>> k) + ((v >>> (k - 1)) & 64'sd1);
  endfunction

  function automatic longint clamp_signed(longint v, int bits);
    longint hi;
    longint lo;
    hi = (64'sd1 <<< (bits - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // Mostly short pauses, now and then a long one.
  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Biased towards the extremes so the saturation paths are visited often.
  function automatic logic signed [VB-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8)  return {1'b1, {(VB-1){1'b0}}};
    if (r < 16) return {1'b0, {(VB-1){1'b1}}};
    if (r < 20) return '0;
    return VB'($urandom);
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
    error_count++;
  endtask

  task automatic advance_shadow(input logic signed [VB-1:0] x, input logic signed [VB-1:0] mean,
                                input logic signed [VB-1:0] spread, input logic last);
    longint mant;
    longint weight;
    longint sum;
    // Step the generator only on the first element of a row, then hold the noise.
    if (shadow_row_start) begin
      shadow_rng = shadow_rng ^ (shadow_rng << XS_SHIFT_A);
      shadow_rng = shadow_rng ^ (shadow_rng >> XS_SHIFT_B);
      shadow_rng = shadow_rng ^ (shadow_rng << XS_SHIFT_C);
      mant = longint'(shadow_rng[MANT_BITS-1:0]) - (64'sd1 <<< (MANT_BITS - 1));
      shadow_noise = round_shr(mant * longint'({1'b0, shadow_drift}), DRIFT_FRAC);
      shadow_row_start = 1'b0;
    end
    weight = clamp_signed(longint'(mean) + round_shr(longint'(spread) * shadow_noise,
                                                     NOISE_FRAC), VB);
    shadow_acc = clamp_signed(shadow_acc + longint'(x) * weight, AB);
    if (last) begin
      sum = clamp_signed(round_shr(shadow_acc, FRAC_BITS), SUM_BITS);
      pending_sums.push_back(sum[SUM_BITS-1:0]);
      shadow_acc = 0;
      shadow_row_start = 1'b1;
    end
  endtask

  // Offer one element word, idling first at random; the shadow advances on acceptance.
  // Valid is left high on return so back-to-back words need no second assignment.
  task automatic send_element(input logic signed [VB-1:0] x, input logic signed [VB-1:0] mean,
                              input logic signed [VB-1:0] spread, input logic last);
    if (!full_rate && $urandom_range(0, 99) < 40) begin
      in_bus.valid <= 1'b0;
      repeat (pick_pause()) @(posedge clk);
    end
    in_bus.valid         <= 1'b1;
    in_bus.x_value       <= x;
    in_bus.weight_mean   <= mean;
    in_bus.weight_spread <= spread;
    in_bus.last_of_row   <= last;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    advance_shadow(x, mean, spread, last);
  endtask

  // Drop valid and hold until every queued row sum has come back.
  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending_sums.size() != 0) @(posedge clk);
  endtask

  // A word that yields no sum may still be in flight, so let the block settle too.
  task automatic wait_idle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] index,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= data;
    @(posedge clk);
    if (index == CFG_DRIFT_GAIN) begin
      shadow_drift = data[DRIFT_BITS-1:0];
    end else begin
      shadow_rng = data;
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [DRIFT_BITS-1:0] drift, input logic [SEED_BITS-1:0] seed);
    wait_idle();
    write_reg(CFG_DRIFT_GAIN, CFG_DATA_BITS'(drift));
    write_reg(CFG_SEED_VALUE, seed);
  endtask

  // Result side: check each accepted row sum, stall ready at random.
  initial begin
    int stall_left;
    logic signed [SUM_BITS-1:0] want;
    stall_left = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_bus.valid && out_bus.ready) begin
        if (pending_sums.size() == 0) begin
          report_mismatch("row sum with no row pending", longint'(out_bus.row_sum), 0);
        end else begin
          want = pending_sums.pop_front();
          if (out_bus.row_sum !== want) begin
            report_mismatch("row_sum", longint'(out_bus.row_sum), longint'(want));
          end
        end
      end
      if (!rst_n) begin
        out_bus.ready <= 1'b0;
      end else if (full_rate) begin
        out_bus.ready <= 1'b1;
        stall_left = 0;
      end else if (stall_left > 0) begin
        out_bus.ready <= 1'b0;
        stall_left--;
      end else begin
        out_bus.ready <= 1'b1;
        if ($urandom_range(0, 99) < 30) stall_left = pick_pause();
      end
    end
  end

  // Defaults after reset: seed 1, drift 0.45. Two one-element rows, then a short row.
  task automatic test_reset_defaults();
    send_element(16'sd4096, 16'sd4096, 16'sd4096, 1'b1);
    send_element(16'sd4096, -16'sd2048, 16'sd8192, 1'b1);
    send_element(-16'sd1234, 16'sd3000, -16'sd7000, 1'b0);
    send_element(16'sd20000, -16'sd15000, 16'sd32767, 1'b0);
    send_element(16'sd1, 16'sd1, 16'sd1, 1'b1);
    // Hold the sender until all sums are back before moving on.
    wait_drained();
  endtask

  // Zero seed keeps the generator at zero, so noise sits at its most negative.
  // With full drift the spread term drives the weight into saturation both ways.
  task automatic test_zero_seed();
    configure(16'hFFFF, '0);
    send_element(16'sd32767, 16'sd32767, -16'sd32768, 1'b1);
    send_element(-16'sd32768, 16'sd32767, -16'sd32768, 1'b1);
    send_element(16'sd32767, -16'sd32768, 16'sd32767, 1'b0);
    send_element(-16'sd32768, -16'sd32768, 16'sd32767, 1'b1);
    configure(16'h0000, '0);
    send_element(16'sd32767, 16'sd100, 16'sd32767, 1'b0);
    send_element(-16'sd32768, -16'sd100, -16'sd32768, 1'b1);
  endtask

  // Extremes of every value field with a live generator and maximum drift.
  task automatic test_field_extremes();
    configure(16'hFFFF, {SEED_BITS{1'b1}});
    send_element(-16'sd32768, -16'sd32768, -16'sd32768, 1'b0);
    send_element(16'sd32767, 16'sd32767, 16'sd32767, 1'b1);
    send_element(16'sd0, 16'sd32767, -16'sd32768, 1'b1);
    send_element(16'sd32767, 16'sd0, -16'sd32768, 1'b0);
    send_element(-16'sd32768, 16'sd0, 16'sd32767, 1'b1);
    send_element(16'sd32767, -16'sd32768, 16'sd0, 1'b1);
  endtask

  // Registers written between elements of one row: the seed replaces the generator
  // at once, the drift only shows from the next row.
  task automatic test_mid_row_writes();
    configure(DRIFT_RESET, 64'h0123_4567_89AB_CDEF);
    send_element(16'sd5000, 16'sd1000, 16'sd12000, 1'b0);
    send_element(-16'sd7000, 16'sd2000, -16'sd9000, 1'b0);
    configure(16'd40000, 64'hFEDC_BA98_7654_3210);
    send_element(16'sd3000, -16'sd4000, 16'sd30000, 1'b1);
    send_element(16'sd3000, -16'sd4000, 16'sd30000, 1'b1);
  endtask

  // Long rows of maximum products carry the accumulator far past 32 bits both ways.
  task automatic test_long_rows();
    int i;
    configure(16'h0000, SEED_RESET);
    full_rate = 1'b1;
    for (i = 0; i < LONG_ROW; i++) begin
      send_element(-16'sd32768, -16'sd32768, 16'sd0, i == LONG_ROW - 1);
    end
    for (i = 0; i < LONG_ROW; i++) begin
      send_element(16'sd32767, -16'sd32768, pick_value(), i == LONG_ROW - 1);
    end
    wait_drained();
    full_rate = 1'b0;
  endtask

  task automatic reconfigure_random();
    logic [DRIFT_BITS-1:0] drift;
    logic [SEED_BITS-1:0]  seed;
    int r;
    r = $urandom_range(0, 9);
    drift = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF : DRIFT_BITS'($urandom);
    r = $urandom_range(0, 9);
    seed = (r == 0) ? '0 : (r == 1) ? {SEED_BITS{1'b1}} : {$urandom, $urandom};
    configure(drift, seed);
  endtask

  // Random rows, mostly short, with occasional reconfiguration and full drains.
  task automatic test_random_rows();
    int sent;
    int len;
    int r;
    int i;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 11) == 0) reconfigure_random();
      r = $urandom_range(0, 99);
      len = (r < 15) ? 1 : (r < 85) ? $urandom_range(2, 8) : $urandom_range(9, 24);
      // Advance through one stretch at full rate now and then.
      full_rate = ($urandom_range(0, 9) == 0);
      for (i = 0; i < len; i++) begin
        send_element(pick_value(), pick_value(), pick_value(), i == len - 1);
        sent++;
      end
      if ($urandom_range(0, 19) == 0) wait_drained();
    end
    full_rate = 1'b0;
  endtask

  initial begin
    error_count      = 0;
    full_rate        = 1'b0;
    shadow_drift     = DRIFT_RESET;
    shadow_rng       = SEED_RESET;
    shadow_noise     = 0;
    shadow_acc       = 0;
    shadow_row_start = 1'b1;
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_index            = CFG_DRIFT_GAIN;
    cfg_wdata            = '0;
    in_bus.valid         = 1'b0;
    in_bus.x_value       = '0;
    in_bus.weight_mean   = '0;
    in_bus.weight_spread = '0;
    in_bus.last_of_row   = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_zero_seed();
    test_field_extremes();
    test_mid_row_writes();
    test_long_rows();
    test_random_rows();

    wait_idle();
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #60_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
